// ===== hw/rtl/lsf_pkg.sv =====
// Shared types, register indexes and helpers for the line substring filter.
package lsf_pkg;

   localparam int MAX_PATTERN_DEFAULT = 32;
   localparam int MAX_LINE_DEFAULT    = 255;
   localparam int PATTERN_BYTES       = 32;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] UPPER_FIRST  = 8'd65;
   localparam logic [7:0] UPPER_LAST   = 8'd90;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [2:0] {
      CSR_PATTERN_WORD0  = 3'd0,
      CSR_PATTERN_WORD1  = 3'd1,
      CSR_PATTERN_WORD2  = 3'd2,
      CSR_PATTERN_WORD3  = 3'd3,
      CSR_PATTERN_LEN    = 3'd4,
      CSR_INVERT_SELECT  = 3'd5,
      CSR_FOLD_CASE      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [31:0] line_number;
      logic        selected;
      logic [31:0] selected_count;
   } rsp_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      if (en && b >= UPPER_FIRST && b <= UPPER_LAST) begin
         return b + CASE_OFFSET;
      end
      return b;
   endfunction

endpackage

// ===== hw/rtl/lsf_window_match.sv =====
// Parallel compare of the newest window bytes against the active pattern.
module lsf_window_match import lsf_pkg::*; #(
   parameter int MaxPattern = MAX_PATTERN_DEFAULT
) (
   input  logic [MaxPattern-1:0][7:0]      window_bytes,
   input  logic [MaxPattern-1:0][7:0]      pattern_bytes,
   input  logic [$clog2(MaxPattern+1)-1:0] pattern_len,
   input  logic                            fold_case,
   output logic                            match
);

   localparam int PLW = $clog2(MaxPattern + 1);
   localparam int IW  = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

   logic [MaxPattern-1:0] pos_ok;

   // window position i pairs with pattern byte pattern_len-1-i
   always_comb begin
      logic [PLW-1:0] pidx;
      for (int i = 0; i < MaxPattern; i++) begin
         pidx = pattern_len - PLW'(i) - PLW'(1);
         if (PLW'(i) < pattern_len) begin
            pos_ok[i] = fold_byte(window_bytes[i], fold_case) ==
                        fold_byte(pattern_bytes[pidx[IW-1:0]], fold_case);
         end else begin
            pos_ok[i] = 1'b1;
         end
      end
   end

   assign match = &pos_ok;

endmodule

// ===== hw/rtl/line_substring_filter.sv =====
// Top level: fixed-string line filter over a byte stream.
//
//   channel  dir  handshake         payload
//   req_     in   valid / stall     req_type  (text_byte, stream_end)
//   rsp_     out  valid / stall     rsp_type  (line_number, selected, selected_count)
//   csr_     in   valid / ready     index 3b, data 64b
//
// One byte per cycle sustained unless rsp_stall holds a result.
// The window compare and state update run on the input register.
// A line result is held in the output register; rsp_stall stalls the input
// register, and req_stall follows when that register is occupied.
// Synchronous reset clears control state and counters; no clearing pass.
module line_substring_filter import lsf_pkg::*; #(
   parameter int MaxPattern = MAX_PATTERN_DEFAULT,
   parameter int MaxLine    = MAX_LINE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int PLW = $clog2(MaxPattern + 1);
   localparam int LLW = $clog2(MaxLine + 1);

   logic [3:0][63:0] pat_word_ff;
   logic [5:0]       pat_len_ff;
   logic             invert_ff;
   logic             fold_ff;

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_ff;

   logic [MaxPattern-1:0][7:0] win_ff, win_in, win_new;
   logic [LLW-1:0]   len_ff, len_in, len_new;
   logic             found_ff, found_in;
   logic [31:0]      line_cnt_ff, line_cnt_in;
   logic [31:0]      sel_cnt_ff, sel_cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             advance, process, accept;
   logic [PLW-1:0]   plen;
   logic             win_match;
   logic [PATTERN_BYTES-1:0][7:0] pat_all;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_word_ff <= '0;
         pat_len_ff  <= '0;
         invert_ff   <= 1'b0;
         fold_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_WORD0: pat_word_ff[0] <= csr_data;
            CSR_PATTERN_WORD1: pat_word_ff[1] <= csr_data;
            CSR_PATTERN_WORD2: pat_word_ff[2] <= csr_data;
            CSR_PATTERN_WORD3: pat_word_ff[3] <= csr_data;
            CSR_PATTERN_LEN:   pat_len_ff     <= csr_data[5:0];
            CSR_INVERT_SELECT: invert_ff      <= csr_data[0];
            CSR_FOLD_CASE:     fold_ff        <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign pat_all = pat_word_ff;
   assign plen = (32'(pat_len_ff) > 32'(MaxPattern)) ? PLW'(MaxPattern) : PLW'(pat_len_ff);

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign process   = s1_valid_ff && advance;

   always_comb begin
      win_new[0] = s1_ff.text_byte;
      for (int i = 1; i < MaxPattern; i++) begin
         win_new[i] = win_ff[i-1];
      end
   end

   assign len_new = len_ff + LLW'(1);

   lsf_window_match #(.MaxPattern(MaxPattern)) u_match (
      .window_bytes  (win_new),
      .pattern_bytes (pat_all[MaxPattern-1:0]),
      .pattern_len   (plen),
      .fold_case     (fold_ff),
      .match         (win_match)
   );

   always_comb begin
      logic finish, hit, sel, found_now;
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      win_in       = win_ff;
      len_in       = len_ff;
      found_in     = found_ff;
      line_cnt_in  = line_cnt_ff;
      sel_cnt_in   = sel_cnt_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;
      finish       = 1'b0;
      hit          = 1'b0;
      sel          = 1'b0;
      found_now    = found_ff;
      if (process) begin
         if (s1_ff.text_byte == NEWLINE_BYTE) begin
            finish = 1'b1;
         end else begin
            if (32'(len_ff) < 32'(MaxLine)) begin
               win_in = win_new;
               len_in = len_new;
               if (plen != '0 && 32'(len_new) >= 32'(plen) && win_match) begin
                  found_now = 1'b1;
               end
            end
            finish = s1_ff.stream_end;
         end
         found_in = found_now;
         hit = (plen == '0) ? 1'b1 : found_now;
         sel = invert_ff ? !hit : hit;
         if (finish) begin
            line_cnt_in = (line_cnt_ff != '1) ? line_cnt_ff + 32'd1 : line_cnt_ff;
            sel_cnt_in  = (sel && sel_cnt_ff != '1) ? sel_cnt_ff + 32'd1 : sel_cnt_ff;
            rsp_valid_in = 1'b1;
            rsp_in.line_number    = line_cnt_in;
            rsp_in.selected       = sel;
            rsp_in.selected_count = sel_cnt_in;
            len_in   = '0;
            found_in = 1'b0;
         end
         if (s1_ff.stream_end) begin
            line_cnt_in = '0;
            sel_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         len_ff       <= '0;
         found_ff     <= 1'b0;
         line_cnt_ff  <= '0;
         sel_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         len_ff       <= len_in;
         found_ff     <= found_in;
         line_cnt_ff  <= line_cnt_in;
         sel_cnt_ff   <= sel_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_data;
      end
      win_ff <= win_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_newline_emits: assert property (@(posedge clock) disable iff (reset)
      process && s1_ff.text_byte == NEWLINE_BYTE |=> rsp_valid)
      else $error("newline transfer produced no result");

   a_end_clears_counts: assert property (@(posedge clock) disable iff (reset)
      process && s1_ff.stream_end |=> line_cnt_ff == '0 && sel_cnt_ff == '0)
      else $error("counters not cleared after stream end");

   a_sel_le_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.selected_count <= rsp_data.line_number)
      else $error("selected count exceeds line number");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= 32'(MaxLine))
      else $error("line length past limit");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with free pipeline");
`endif

endmodule
